>>> rtl/srp_pkg.sv
// Shared types, codes and constants of the slant-stack point engine.
package srp_pkg;

  localparam int TRACE_W  = 6;
  localparam int SAMPLE_W = 10;
  localparam int SLOPE_W  = 8;
  localparam int VALUE_W  = 16;
  localparam int COORD_W  = 24;
  localparam int STEP_W   = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int MAX_TRACES  = 64;
  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 28;
  localparam int SUM_W       = 23;
  localparam int QUO_W       = 22;
  localparam int DIV_CNT_W   = 5;
  localparam int PROD_W      = 64;
  localparam int SMAG_W      = 40;
  localparam int HALF_W      = 20;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_COORD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_TRACE_COUNT  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_COUNT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SLOPE_MIN    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SLOPE_STEP   = 3'd4;

  typedef struct packed {
    logic [1:0]                 func;
    logic [TRACE_W-1:0]         trace_index;
    logic [SAMPLE_W-1:0]        sample_index;
    logic [SLOPE_W-1:0]         slope_index;
    logic signed [VALUE_W-1:0]  sample_value;
    logic signed [COORD_W-1:0]  coord_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  stacked_value;
    logic [SLOPE_W-1:0]         slope_index_echo;
    logic [SAMPLE_W-1:0]        tau_index_echo;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOPE, ST_ABS, ST_RDC, ST_DIS, ST_MLO, ST_MHI,
    ST_POS, ST_RDS, ST_ACC, ST_DIVI, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_SLOPE, CMD_ABS, CMD_DIS, CMD_MLO, CMD_MHI,
    CMD_POS, CMD_ACC, CMD_DIVI, CMD_DIV, CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic ntr_zero;
    logic trace_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/srp_ctrl.sv
// Controller state machine sequencing loads, the per-trace stack loop and the divide.
module srp_ctrl import srp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic [1:0] in_func,
  input  status_t stat,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_func == FUNC_QUERY) state_nxt = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd = CMD_SLOPE;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd = CMD_ABS;
        state_nxt = stat.ntr_zero ? ST_DIVI : ST_RDC;
      end
      ST_RDC: state_nxt = ST_DIS;
      ST_DIS: begin
        cmd = CMD_DIS;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        cmd = CMD_MLO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        cmd = CMD_MHI;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        cmd = CMD_POS;
        state_nxt = ST_RDS;
      end
      ST_RDS: state_nxt = ST_ACC;
      ST_ACC: begin
        cmd = CMD_ACC;
        state_nxt = stat.trace_last ? ST_DIVI : ST_RDC;
      end
      ST_DIVI: begin
        cmd = CMD_DIVI;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd = CMD_DIV;
        if (stat.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd = CMD_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/srp_dp.sv
// Datapath: configuration, sample and coordinate stores, shift arithmetic, accumulator, divider.
module srp_dp import srp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_fire,
  input  in_item_t          in_data,
  input  cmd_t              cmd,
  output status_t           stat,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic [6:0]                 trace_count_r;
  logic [10:0]                sample_count_r;
  logic signed [COORD_W-1:0]  center_r;
  logic signed [STEP_W-1:0]   slope_min_r, slope_step_r;

  logic signed [VALUE_W-1:0]  sample_mem [MAX_TRACES*MAX_SAMPLES];
  logic signed [COORD_W-1:0]  coord_mem [MAX_TRACES];
  logic signed [VALUE_W-1:0]  sample_q_r;
  logic signed [COORD_W-1:0]  coord_q_r;

  logic [SAMPLE_W-1:0]        tau_r;
  logic [SLOPE_W-1:0]         slope_idx_r;
  logic signed [STEP_W+SLOPE_W:0] step_prod_r;
  logic                       slope_neg_r;
  logic [SMAG_W-1:0]          slope_mag_r;
  logic                       dis_neg_r;
  logic [COORD_W-1:0]         dis_mag_r;
  logic [PROD_W-1:0]          prod_r;
  logic [SAMPLE_W-1:0]        pos_r;
  logic                       pos_ok_r;
  logic [6:0]                 trace_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [QUO_W-1:0]           quo_r;
  logic [7:0]                 rem_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;
  logic                       out_valid_r;
  out_item_t                  out_r;

  logic [6:0]                 ntr;
  logic [10:0]                ns;
  logic signed [STEP_W+SLOPE_W+1:0] slope_full;
  logic signed [COORD_W:0]    dis_full;
  logic [35:0]                shift_mag;
  logic signed [12:0]         pos_full;
  logic [8:0]                 rem_sh;
  logic [QUO_W-1:0]           mean_mag;
  logic [QUO_W-1:0]           mean_s;

  assign ntr = (trace_count_r > 7'(MAX_TRACES)) ? 7'(MAX_TRACES) : trace_count_r;
  assign ns  = (sample_count_r > 11'(MAX_SAMPLES)) ? 11'(MAX_SAMPLES) : sample_count_r;
  assign slope_full = (STEP_W+SLOPE_W+2)'(slope_min_r) + (STEP_W+SLOPE_W+2)'(step_prod_r);
  assign dis_full  = (COORD_W+1)'(coord_q_r) - (COORD_W+1)'(center_r);
  assign shift_mag = prod_r[PROD_W-1:FRAC_BITS];
  assign pos_full  = dis_neg_r ^ slope_neg_r
                     ? 13'(tau_r) - 13'(shift_mag[10:0])
                     : 13'(tau_r) + 13'(shift_mag[10:0]);
  assign rem_sh    = {rem_r, quo_r[QUO_W-1]};
  assign mean_mag  = quo_r;
  assign mean_s    = sum_r[SUM_W-1] ? (QUO_W)'(0) - mean_mag : mean_mag;

  assign stat.ntr_zero   = (ntr == 7'd0);
  assign stat.trace_last = (trace_r + 7'd1 == ntr);
  assign stat.div_last   = (div_cnt_r == DIV_CNT_W'(QUO_W - 1));
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_count_r  <= 7'd64;
      sample_count_r <= 11'd1024;
      center_r       <= '0;
      slope_min_r    <= '0;
      slope_step_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TRACE_COUNT:  trace_count_r  <= cfg_wdata[6:0];
        REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[10:0];
        REG_CENTER:       center_r       <= cfg_wdata[COORD_W-1:0];
        REG_SLOPE_MIN:    slope_min_r    <= cfg_wdata;
        REG_SLOPE_STEP:   slope_step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.func == FUNC_SAMPLE) begin
      sample_mem[{in_data.trace_index, in_data.sample_index}] <= in_data.sample_value;
    end
    sample_q_r <= sample_mem[{trace_r[TRACE_W-1:0], pos_r}];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.func == FUNC_COORD) begin
      coord_mem[in_data.trace_index] <= in_data.coord_value;
    end
    coord_q_r <= coord_mem[trace_r[TRACE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.func == FUNC_QUERY) begin
      tau_r       <= in_data.sample_index;
      slope_idx_r <= in_data.slope_index;
    end
    case (cmd)
      CMD_SLOPE: step_prod_r <= slope_step_r * $signed({1'b0, slope_idx_r});
      CMD_ABS: begin
        slope_neg_r <= slope_full[STEP_W+SLOPE_W+1];
        slope_mag_r <= slope_full[STEP_W+SLOPE_W+1]
                       ? SMAG_W'(-slope_full) : SMAG_W'(slope_full);
        trace_r <= '0;
        sum_r   <= '0;
      end
      CMD_DIS: begin
        dis_neg_r <= dis_full[COORD_W];
        dis_mag_r <= dis_full[COORD_W] ? COORD_W'(-dis_full) : COORD_W'(dis_full);
      end
      CMD_MLO: prod_r <= PROD_W'(dis_mag_r * slope_mag_r[HALF_W-1:0]);
      CMD_MHI: prod_r <= prod_r
                         + (PROD_W'(dis_mag_r * slope_mag_r[SMAG_W-1:HALF_W]) << HALF_W);
      CMD_POS: begin
        pos_r    <= pos_full[SAMPLE_W-1:0];
        pos_ok_r <= (shift_mag[35:11] == '0) && !pos_full[12]
                    && (pos_full[11:0] < 12'(ns));
      end
      CMD_ACC: begin
        if (pos_ok_r) sum_r <= sum_r + SUM_W'(sample_q_r);
        trace_r <= trace_r + 7'd1;
      end
      CMD_DIVI: begin
        quo_r     <= sum_r[SUM_W-1] ? QUO_W'(-sum_r) : QUO_W'(sum_r);
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      CMD_DIV: begin
        if (rem_sh >= 9'(ntr)) begin
          rem_r <= 8'(rem_sh - 9'(ntr));
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[7:0];
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      CMD_OUT: begin
        out_r.stacked_value    <= stat.ntr_zero ? '0 : mean_s[VALUE_W-1:0];
        out_r.slope_index_echo <= slope_idx_r;
        out_r.tau_index_echo   <= tau_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

>>> rtl/slant_stack_radon_point.sv
// Top level of the slant-stack point engine: controller plus datapath.
//  channel | signals                          | role
//  in      | in_valid, in_ready, in_data      | loads and queries
//  out     | out_valid, out_ready, out_data   | one stacked value per query
//  cfg     | cfg_we, cfg_addr, cfg_wdata      | register writes, no wait
// A query sets up the slope, then per stacked trace reads the coordinate, forms the distance,
// multiplies by the slope in two halves, forms the sample position, reads the sample and
// accumulates, then divides bit-serially by the trace count and writes the result.
// Synchronous active-low reset; the stores are not cleared.
// A query whose result cannot yet be written holds until out_ready frees the output register.
module slant_stack_radon_point import srp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  cmd_t    cmd;
  status_t stat;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  srp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  srp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the slant-stack point engine with its own stack predictor.
module tb_top import srp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 600;
  localparam int HOLD_LEN   = 700;
  localparam int IN_W       = $bits(in_item_t);

  class stack_scoreboard;
    int unsigned             trace_cnt;
    int unsigned             sample_cnt;
    longint                  center;
    longint                  slope_first;
    longint                  slope_inc;
    logic signed [15:0]      samples[MAX_TRACES*MAX_SAMPLES];
    bit                      sample_known[MAX_TRACES*MAX_SAMPLES];
    logic signed [23:0]      coords[MAX_TRACES];
    out_item_t               pending[$];
    int                      errors;

    function new();
      trace_cnt   = 64;
      sample_cnt  = 1024;
      center      = 0;
      slope_first = 0;
      slope_inc   = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] v);
      case (addr)
        REG_TRACE_COUNT:  trace_cnt = v[6:0];
        REG_SAMPLE_COUNT: sample_cnt = v[10:0];
        REG_CENTER:       center = longint'($signed(v[23:0]));
        REG_SLOPE_MIN:    slope_first = longint'($signed(v));
        REG_SLOPE_STEP:   slope_inc = longint'($signed(v));
        default: ;
      endcase
    endfunction

    // Stack one point; return the first unwritten sample it would read, or -1.
    function int stack_point(in_item_t it, output out_item_t r);
      int     ntr;
      int     gap;
      int     idx;
      longint ns;
      longint slope;
      longint dis;
      longint shift;
      longint pos;
      longint sum;
      logic [63:0] prod;
      logic [63:0] mag;
      ntr   = (trace_cnt > MAX_TRACES) ? MAX_TRACES : trace_cnt;
      ns    = (sample_cnt > MAX_SAMPLES) ? MAX_SAMPLES : sample_cnt;
      slope = slope_first + slope_inc * longint'(it.slope_index);
      gap   = -1;
      sum   = 0;
      for (int t = 0; t < ntr; t++) begin
        dis  = longint'(coords[t]) - center;
        prod = dis * slope;
        if (prod[63]) begin
          mag   = -prod;
          shift = -longint'(mag >> FRAC_BITS);
        end else begin
          shift = longint'(prod >> FRAC_BITS);
        end
        pos = longint'(it.sample_index) + shift;
        if (pos >= 0 && pos < ns) begin
          idx = t * MAX_SAMPLES + int'(pos);
          if (!sample_known[idx] && gap < 0) gap = idx;
          sum += samples[idx];
        end
      end
      r.stacked_value    = (ntr != 0) ? 16'(sum / longint'(ntr)) : '0;
      r.slope_index_echo = it.slope_index;
      r.tau_index_echo   = it.sample_index;
      return gap;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      case (it.func)
        FUNC_SAMPLE: begin
          samples[it.trace_index*MAX_SAMPLES + it.sample_index] = it.sample_value;
          sample_known[it.trace_index*MAX_SAMPLES + it.sample_index] = 1'b1;
        end
        FUNC_COORD: coords[it.trace_index] = it.coord_value;
        FUNC_QUERY: begin
          void'(stack_point(it, r));
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.stacked_value !== exp_r.stacked_value) begin
        $display("%0t: stacked_value expected %0d actual %0d", $time,
                 exp_r.stacked_value, got.stacked_value);
        errors++;
      end
      if (got.slope_index_echo !== exp_r.slope_index_echo) begin
        $display("%0t: slope_index_echo expected %0d actual %0d", $time,
                 exp_r.slope_index_echo, got.slope_index_echo);
        errors++;
      end
      if (got.tau_index_echo !== exp_r.tau_index_echo) begin
        $display("%0t: tau_index_echo expected %0d actual %0d", $time,
                 exp_r.tau_index_echo, got.tau_index_echo);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  stack_scoreboard sb = new();
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;

  slant_stack_radon_point dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    return it;
  endfunction

  task automatic load_sample(int trace, int idx, logic [15:0] v);
    in_item_t it;
    it = noise_item();
    it.func         = FUNC_SAMPLE;
    it.trace_index  = TRACE_W'(trace);
    it.sample_index = SAMPLE_W'(idx);
    it.sample_value = v;
    send_item(it);
  endtask

  task automatic load_coord(int trace, logic [23:0] v);
    in_item_t it;
    it = noise_item();
    it.func        = FUNC_COORD;
    it.trace_index = TRACE_W'(trace);
    it.coord_value = v;
    send_item(it);
  endtask

  // Fill every sample the query would read, then issue it.
  task automatic send_query(int slope, int tau);
    in_item_t  it;
    out_item_t r;
    int        gap;
    it = noise_item();
    it.func         = FUNC_QUERY;
    it.slope_index  = SLOPE_W'(slope);
    it.sample_index = SAMPLE_W'(tau);
    gap = sb.stack_point(it, r);
    while (gap >= 0) begin
      load_sample(gap / MAX_SAMPLES, gap % MAX_SAMPLES, 16'($urandom));
      gap = sb.stack_point(it, r);
    end
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_regs(logic [CFG_DW-1:0] tc, logic [CFG_DW-1:0] sc,
                            logic [CFG_DW-1:0] ctr, logic [CFG_DW-1:0] smin,
                            logic [CFG_DW-1:0] sstep);
    logic [CFG_DW-1:0] vals[5];
    logic [CFG_AW-1:0] addrs[5];
    vals  = '{tc, sc, ctr, smin, sstep};
    addrs = '{REG_TRACE_COUNT, REG_SAMPLE_COUNT, REG_CENTER, REG_SLOPE_MIN, REG_SLOPE_STEP};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      sb.write_reg(addrs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count, int tau_max);
    int r;
    int tau;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      tau = ($urandom_range(99) < 80) ? $urandom_range(0, tau_max) : $urandom_range(1023);
      if (r < 5) begin
        send_item(in_item_t'({2'd3, 64'(noise_item())}));
      end else if (r < 30) begin
        load_sample($urandom_range(63), tau, 16'($urandom));
      end else if (r < 40) begin
        load_coord($urandom_range(63), 24'($urandom));
      end else begin
        send_query($urandom_range(255), tau);
      end
    end
  endtask

  initial begin
    logic [31:0] small_min;
    logic [31:0] small_step;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_coord(0, 24'h800000);
    load_coord(63, 24'h7FFFFF);
    for (int t = 1; t < 63; t++) load_coord(t, 24'($urandom));

    load_sample(63, 1023, 16'h8000);
    load_sample(0, 0, 16'h7FFF);
    send_item(in_item_t'({2'd3, 64'(noise_item())}));
    send_query(0, 0);
    send_query(255, 1023);
    send_query(128, 0);

    drain();
    apply_regs(1, 16, 0, 32'h1000_0000, 32'h0100_0000);
    hold_req = 1'b1;
    random_items(100, 20);

    drain();
    quiet = 1'b1;
    apply_regs(64, 16, 32'hFF80_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    random_items(100, 20);
    quiet = 1'b0;

    drain();
    apply_regs(0, 8, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    random_items(60, 12);

    drain();
    apply_regs(127, 2047, 100, 0, 0);
    random_items(20, 3);

    drain();
    apply_regs(64, 0, $urandom, $urandom, $urandom);
    random_items(60, 20);

    for (int p = 0; p < 6; p++) begin
      drain();
      small_min  = $urandom_range(32768) - 16384;
      small_step = $urandom_range(512) - 256;
      if (p % 2) apply_regs($urandom_range(1, 64), $urandom_range(4, 32), $urandom,
                            $urandom, $urandom);
      else       apply_regs($urandom_range(1, 64), $urandom_range(4, 32), $urandom,
                            small_min, small_step);
      random_items(60, 36);
    end

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
